// ===== rtl/dbgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Directory byte group scrambler package
// Shared item types, group descriptor, configuration indexes and sizes.
// ----------------------------------------------------------------------------
package dbgs_pkg;

    localparam int unsigned GROUP_BYTES = 4;
    localparam int unsigned HELD_BYTES  = GROUP_BYTES - 1;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION      = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic v3;
        logic enc;
    } t_cfg;

    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] bytes;
        logic [1:0]                  count_m1;
        logic                        last;
        t_cfg                        cfg;
    } t_group;

endpackage

// ===== rtl/directory_byte_group_scrambler.sv =====
// ----------------------------------------------------------------------------
// Directory byte group scrambler
// Scrambles or unscrambles a directory byte stream in groups of four bytes.
// ----------------------------------------------------------------------------
// Input channel: one byte per item with a last-byte flag, valid/ready.
// Output channel: one transformed byte per item with a last flag, valid/ready.
// Bytes are held until a group of four completes or the last byte arrives;
// then one result per held byte comes out in stream order.
// A closed group is written into the queue, popped into the back end's result register,
// and its bytes then pass through the output register one per cycle while the receiver is ready.
// Throughput: one byte per cycle in and out unless the receiver stalls, set by the single output
// register of the back end; a two-group queue separates front and back.
// Configuration: write format_version (index 0) and direction (index 1)
// through the write port while no stream is in flight.
// Reset clears the fill count, the queue and the output stage; both
// configuration registers return to zero (version 2, decode).
// When the receiver stalls, the output holds, the back end waits, the queue
// fills, and then input ready drops.
// ----------------------------------------------------------------------------
module directory_byte_group_scrambler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dbgs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbgs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dbgs_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dbgs_pkg::t_out_item                 o_out_item
);

    dbgs_pkg::t_cfg   r_cfg;
    logic             q_full;
    logic             q_push;
    dbgs_pkg::t_group q_in_group;
    logic             q_pop;
    logic             q_valid;
    dbgs_pkg::t_group q_out_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dbgs_pkg::CFG_FORMAT_VERSION: r_cfg.v3  <= i_cfg_data[0];
                dbgs_pkg::CFG_DIRECTION:      r_cfg.enc <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dbgs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_group  (q_in_group)
    );

    dbgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (q_in_group),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_group (q_out_group)
    );

    dbgs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_group   (q_out_group),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/dbgs_front.sv =====
// ----------------------------------------------------------------------------
// Directory byte group scrambler front end
// Accepts bytes, holds up to three, and hands a complete group or tail on.
// ----------------------------------------------------------------------------
module dbgs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dbgs_pkg::t_in_item i_in_item,
    input  dbgs_pkg::t_cfg    i_cfg,
    input  logic              i_q_full,
    output logic              o_q_push,
    output dbgs_pkg::t_group  o_q_group
);

    logic [dbgs_pkg::HELD_BYTES-1:0][7:0] r_buf;
    logic [1:0]                           r_fill;
    logic [1:0]                           n_fill;
    logic                                 accept;
    logic                                 close;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign close      = (r_fill == 2'd3) || i_in_item.last_byte;
    assign o_q_push   = accept && close;

    always_comb begin
        for (int i = 0; i < dbgs_pkg::HELD_BYTES; i++) begin
            if (i < int'(r_fill)) begin
                o_q_group.bytes[i] = r_buf[i];
            end else begin
                o_q_group.bytes[i] = i_in_item.in_byte;
            end
        end
        o_q_group.bytes[dbgs_pkg::GROUP_BYTES-1] = i_in_item.in_byte;
        o_q_group.count_m1 = r_fill;
        o_q_group.last     = i_in_item.last_byte;
        o_q_group.cfg      = i_cfg;
    end

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            n_fill = close ? 2'd0 : r_fill + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !close) begin
            r_buf[r_fill] <= i_in_item.in_byte;
        end
    end

endmodule

// ===== rtl/dbgs_queue.sv =====
// ----------------------------------------------------------------------------
// Directory byte group scrambler queue
// Short group queue between front end and back end.
// ----------------------------------------------------------------------------
module dbgs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dbgs_pkg::t_group i_group,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output dbgs_pkg::t_group o_group
);

    localparam int unsigned PTR_W = $clog2(dbgs_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(dbgs_pkg::QUEUE_DEPTH + 1);

    dbgs_pkg::t_group r_mem [dbgs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(dbgs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_group = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(dbgs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(dbgs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

// ===== rtl/dbgs_back.sv =====
// ----------------------------------------------------------------------------
// Directory byte group scrambler back end
// Permutes and inverts bytes of a group; emits one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dbgs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  dbgs_pkg::t_group    i_q_group,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dbgs_pkg::t_out_item o_out_item
);

    logic [dbgs_pkg::GROUP_BYTES-1:0][7:0] r_res;
    logic [dbgs_pkg::GROUP_BYTES-1:0][7:0] res;
    logic [1:0]                            r_idx;
    logic [1:0]                            r_n_m1;
    logic                                  r_last;
    logic                                  r_busy;
    logic                                  r_out_valid;
    dbgs_pkg::t_out_item                   r_out;
    logic                                  advance;
    logic                                  finish;

    always_comb begin
        logic [dbgs_pkg::GROUP_BYTES-1:0][7:0] b;
        b   = i_q_group.bytes;
        res = ~b;
        if (i_q_group.count_m1 == 2'd3) begin
            res[0] = ~b[2];
            res[1] = ~b[3];
            res[2] = ~b[0];
            res[3] = ~b[1];
            if (i_q_group.cfg.v3 && !i_q_group.cfg.enc) begin
                res[2] = b[0];
            end else if (i_q_group.cfg.v3) begin
                res[0] = b[2];
            end
        end else if (i_q_group.cfg.v3) begin
            unique case (i_q_group.count_m1)
                2'd0: begin
                    res[0] = b[0];
                end
                2'd1: begin
                    res[0] = b[0];
                    res[1] = ~b[1];
                end
                default: begin
                    if (!i_q_group.cfg.enc) begin
                        res[0] = ~b[2];
                        res[1] = b[0];
                        res[2] = ~b[1];
                    end else begin
                        res[0] = b[1];
                        res[1] = ~b[2];
                        res[2] = ~b[0];
                    end
                end
            endcase
        end
    end

    assign advance     = !r_out_valid || i_out_ready;
    assign finish      = advance && r_busy && (r_idx == r_n_m1);
    assign o_q_pop     = i_q_valid && (!r_busy || finish);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (finish) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else if (advance && r_busy) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res  <= res;
            r_n_m1 <= i_q_group.count_m1;
            r_last <= i_q_group.last;
        end
        if (advance && r_busy) begin
            r_out.out_byte <= r_res[r_idx];
            r_out.out_last <= r_last && (r_idx == r_n_m1);
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_n_m1))
        else $error("byte index past group size");

    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == 2'd0))
        else $error("byte index nonzero while idle");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_busy && r_idx == 2'd0))
        else $error("popped group not loaded");

    a_last_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_busy && r_last && r_idx == r_n_m1) |=> r_out.out_last)
        else $error("final byte missing last flag");
`endif

endmodule

// ===== tb/directory_byte_group_scrambler_tb.sv =====
// ----------------------------------------------------------------------------
// Directory byte group scrambler testbench
// Sends directory byte streams under every format and direction setting.
// Each accepted byte goes through a local group scrambler that predicts the
// output bytes. Every output item is compared with the oldest prediction.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module directory_byte_group_scrambler_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 13;
    localparam int RANDOM_ITEMS = 190;
    localparam int PHASES       = 5;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [dbgs_pkg::CFG_IDX_W-1:0]  cfg_index = dbgs_pkg::CFG_FORMAT_VERSION;
    logic [dbgs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    dbgs_pkg::t_in_item              in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    dbgs_pkg::t_out_item             out_item;

    logic                cfg_v3  = 1'b0;
    logic                cfg_enc = 1'b0;
    logic [7:0]          held [3];
    int                  held_count = 0;
    dbgs_pkg::t_out_item expected_bytes [$];
    dbgs_pkg::t_out_item want;

    logic sender_idle_en = 1'b1;
    logic recv_stall_en  = 1'b1;
    int   cycle_count    = 0;
    int   errors         = 0;
    int   items_sent     = 0;
    int   streams_sent   = 0;
    int   results_seen   = 0;

    logic [7:0] pattern [4] = '{8'h00, 8'hFF, 8'h96, 8'h69};

    directory_byte_group_scrambler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("directory_byte_group_scrambler verification failed");
            $finish;
        end
    end

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [7:0]          grp [4];
        logic [7:0]          res [4];
        int                  n;
        int                  i;
        dbgs_pkg::t_out_item r;
        if (held_count < 3 && !last) begin
            held[held_count] = b;
            held_count++;
            return;
        end
        for (i = 0; i < held_count; i++)
            grp[i] = held[i];
        grp[held_count] = b;
        n = held_count + 1;
        held_count = 0;
        if (n == 4) begin
            if (!cfg_v3) begin
                res[0] = ~grp[2]; res[1] = ~grp[3]; res[2] = ~grp[0]; res[3] = ~grp[1];
            end else if (!cfg_enc) begin
                res[0] = ~grp[2]; res[1] = ~grp[3]; res[2] = grp[0]; res[3] = ~grp[1];
            end else begin
                res[0] = grp[2]; res[1] = ~grp[3]; res[2] = ~grp[0]; res[3] = ~grp[1];
            end
        end else if (!cfg_v3) begin
            for (i = 0; i < n; i++)
                res[i] = ~grp[i];
        end else if (n == 1) begin
            res[0] = grp[0];
        end else if (n == 2) begin
            res[0] = grp[0]; res[1] = ~grp[1];
        end else if (!cfg_enc) begin
            res[0] = ~grp[2]; res[1] = grp[0]; res[2] = ~grp[1];
        end else begin
            res[0] = grp[1]; res[1] = ~grp[2]; res[2] = ~grp[0];
        end
        for (i = 0; i < n; i++) begin
            r.out_byte = res[i];
            r.out_last = last && (i == n - 1);
            expected_bytes.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {b, last};
        do @(posedge clk); while (in_ready !== 1'b1);
        predict_byte(b, last);
        items_sent++;
        if (last)
            streams_sent++;
    endtask

    task automatic idle_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        idle_input();
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dbgs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbgs_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == dbgs_pkg::CFG_FORMAT_VERSION)
            cfg_v3 = val[0];
        else if (idx == dbgs_pkg::CFG_DIRECTION)
            cfg_enc = val[0];
    endtask

    task automatic set_format(input logic v3, input logic enc);
        wait_for_results();
        write_reg(dbgs_pkg::CFG_FORMAT_VERSION, v3);
        write_reg(dbgs_pkg::CFG_DIRECTION, enc);
    endtask

    task automatic send_pattern(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_byte(pattern[i], i == len - 1);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_v2_group_and_tail();
        set_format(1'b0, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    task automatic test_v3_tails(input logic enc);
        int len;
        set_format(1'b1, enc);
        for (len = 1; len <= 4; len++)
            send_pattern(len);
    endtask

    task automatic test_config_change_mid_group();
        set_format(1'b0, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hED, 1'b0);
        set_format(1'b1, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_random_streams();
        int   phase;
        int   phase_items;
        int   len;
        int   i;
        logic paused;
        logic v3;
        logic enc;
        paused = 1'b0;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin v3 = 1'b0; enc = 1'b0; end
                1:       begin v3 = 1'b1; enc = 1'b0; end
                2:       begin v3 = 1'b1; enc = 1'b1; end
                3:       begin v3 = 1'b0; enc = 1'b1; end
                default: begin v3 = 1'b1; enc = 1'b0; end
            endcase
            set_format(v3, enc);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                   : $urandom_range(1, 8);
                if (len > RANDOM_ITEMS / PHASES - phase_items)
                    len = RANDOM_ITEMS / PHASES - phase_items;
                sender_idle_en = (phase != 1) && ($urandom_range(0, 3) != 0);
                recv_stall_en  = (phase != 1) && ($urandom_range(0, 3) != 0);
                for (i = 0; i < len; i++) begin
                    if (phase == 3 && !paused && phase_items >= 20) begin
                        wait_for_results();
                        paused = 1'b1;
                    end
                    send_byte(random_byte(), i == len - 1);
                    phase_items++;
                end
            end
        end
        sender_idle_en = 1'b1;
        recv_stall_en  = 1'b1;
    endtask

    initial begin
        int gap;
        forever begin
            gap = recv_stall_en ? $urandom_range(0, MAX_GAP) : 0;
            @(negedge clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ready && out_valid === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual byte %h last %b",
                         $time, out_item.out_byte, out_item.out_last);
            end else begin
                want = expected_bytes.pop_front();
                results_seen++;
                if (out_item.out_byte !== want.out_byte) begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.out_byte, out_item.out_byte);
                end
                if (out_item.out_last !== want.out_last) begin
                    errors++;
                    $display("%0t: out_last mismatch: expected %b, actual %b",
                             $time, want.out_last, out_item.out_last);
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_v2_group_and_tail();
        test_v3_tails(1'b0);
        test_v3_tails(1'b1);
        test_config_change_mid_group();
        test_random_streams();
        wait_for_results();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived",
                     $time, expected_bytes.size());
        end
        $display("sent %0d bytes in %0d streams, checked %0d output bytes",
                 items_sent, streams_sent, results_seen);
        $display("both formats and directions, tails of 1 to 3 bytes, full groups, mid-group change");
        if (errors == 0)
            $display("directory_byte_group_scrambler verification clean");
        else
            $display("directory_byte_group_scrambler verification failed");
        $finish;
    end

endmodule
